FILE: src/bba_pkg.sv
package bba_pkg;

  localparam int HeapOrder = 10;
  localparam int HeapSize  = 1 << HeapOrder;
  localparam int AddrW     = HeapOrder;
  localparam int OrdW      = 4;
  localparam int SizeW     = 11;
  localparam int MaskW     = HeapOrder + 1;
  localparam int NodeW     = HeapOrder + 1;
  localparam int NodeDepth = 1 << NodeW;
  localparam int BlkW      = OrdW + 1;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOSPACE  = 2'd1,
    ST_BADSIZE  = 2'd2,
    ST_NOTALLOC = 2'd3
  } status_e;

  typedef struct packed {
    logic             req_type;
    logic [SizeW-1:0] req_size;
    logic [AddrW-1:0] block_address;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [AddrW-1:0] address;
    logic [OrdW-1:0]  order;
  } rsp_t;

  // Smallest order whose block holds the given size.
  function automatic logic [OrdW-1:0] size_order(logic [SizeW-1:0] size);
    logic [OrdW-1:0] k;
    k = OrdW'(HeapOrder);
    for (int i = HeapOrder; i >= 0; i--) begin
      if (((SizeW+1)'(1) << i) >= {1'b0, size}) k = OrdW'(i);
    end
    return k;
  endfunction

  // Heap-ordered tree index of the block at address a with order o.
  function automatic logic [NodeW-1:0] node_idx(logic [AddrW-1:0] a, logic [OrdW-1:0] o);
    logic [NodeW-1:0] first;
    first = (NodeW'(1) << (OrdW'(HeapOrder) - o)) - NodeW'(1);
    return first + NodeW'(a >> o);
  endfunction

  function automatic logic [NodeW-1:0] sibling(logic [NodeW-1:0] n);
    return n[0] ? n + NodeW'(1) : n - NodeW'(1);
  endfunction

  // Bits lo up to hi-1 set.
  function automatic logic [MaskW-1:0] range_mask(logic [OrdW-1:0] lo, logic [OrdW-1:0] hi);
    return ((MaskW'(1) << hi) - MaskW'(1)) & ~((MaskW'(1) << lo) - MaskW'(1));
  endfunction

  // Lowest set bit; the top bit of the result flags that one was found.
  function automatic logic [OrdW:0] lowest_set(logic [MaskW-1:0] m);
    logic [OrdW:0] r;
    r = '0;
    for (int i = MaskW - 1; i >= 0; i--) begin
      if (m[i]) r = {1'b1, OrdW'(i)};
    end
    return r;
  endfunction

endpackage

FILE: src/bba_ram.sv
module bba_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: src/buddy_block_allocator.sv
// Buddy allocator over a heap of 1024 units.
// Requests arrive on in_req_i under in_valid_i / in_stall_o; each request gives
// exactly one response on out_rsp_o under out_valid_o / out_stall_i.
// An allocate request rounds its size up to a power of two and gets the
// lowest-address free block of the smallest sufficient order; a free request
// returns a block and merges it with its buddy for as long as the buddy is free.
// The free tree lives in a node memory holding, per node, the set of orders
// that are free somewhere in its subtree; a single index unit and one memory
// read and one write per cycle do all the work under a small sequencer.
// One request is handled at a time. An allocation walks down the tree, makes
// two writes per split and walks back to the root; a free merges with each
// free buddy in turn and then walks back to the root. Rejected requests skip
// the tree work. After every response the block returns to idle before it
// takes the next request. After reset the block runs a clearing pass over
// the node and block memories and holds in_stall_o high meanwhile.
// A finished response sits in a holding register; if the receiver stalls,
// the block waits with its result until the output register frees up.
module buddy_block_allocator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bba_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bba_pkg::rsp_t out_rsp_o
);

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_AROOT  = 4'd2;
  localparam logic [3:0] S_ADESC  = 4'd3;
  localparam logic [3:0] S_ASPLIT = 4'd4;
  localparam logic [3:0] S_FCHK   = 4'd5;
  localparam logic [3:0] S_FMRG   = 4'd6;
  localparam logic [3:0] S_FZRO   = 4'd7;
  localparam logic [3:0] S_UPRD   = 4'd8;
  localparam logic [3:0] S_UP     = 4'd9;
  localparam logic [3:0] S_RES    = 4'd10;

  localparam logic [bba_pkg::OrdW-1:0]  TopOrd   = bba_pkg::OrdW'(bba_pkg::HeapOrder);
  localparam logic [bba_pkg::MaskW-1:0] RootMask = bba_pkg::MaskW'(1) << bba_pkg::HeapOrder;

  logic [3:0]                  state_q, state_d;
  logic [bba_pkg::NodeW-1:0]   clr_q, clr_d;
  logic [bba_pkg::OrdW-1:0]    k_q, k_d, j_q, j_d, o_q, o_d, so_q, so_d;
  logic                        ph_q, ph_d;
  logic [bba_pkg::AddrW-1:0]   base_q, base_d, addr_q, addr_d;
  logic [bba_pkg::NodeW-1:0]   node_q, node_d;
  logic [bba_pkg::MaskW-1:0]   mask_q, mask_d;
  bba_pkg::rsp_t               res_q, res_d;
  logic                        out_valid_q;
  bba_pkg::rsp_t               out_q;

  // Node memory ports.
  logic                        nd_we;
  logic [bba_pkg::NodeW-1:0]   nd_waddr, nd_raddr;
  logic [bba_pkg::MaskW-1:0]   nd_wdata, nd_rdata;
  // Block memory ports: valid flag over the recorded order.
  logic                        bk_we;
  logic [bba_pkg::AddrW-1:0]   bk_waddr, bk_raddr;
  logic [bba_pkg::BlkW-1:0]    bk_wdata, bk_rdata;

  // Shared index unit.
  logic [bba_pkg::AddrW-1:0]   ix_a;
  logic [bba_pkg::OrdW-1:0]    ix_o;
  logic [bba_pkg::NodeW-1:0]   ix_n;

  logic [bba_pkg::OrdW-1:0]    lvl_dn, lvl_up, f_ord;
  logic [bba_pkg::OrdW:0]      pick;
  logic [bba_pkg::NodeW-1:0]   child_n, parent_n;
  logic [bba_pkg::MaskW-1:0]   parent_m;
  logic                        out_load;

  assign ix_n     = bba_pkg::node_idx(ix_a, ix_o);
  assign lvl_dn   = o_q - bba_pkg::OrdW'(1);
  assign lvl_up   = o_q + bba_pkg::OrdW'(1);
  assign pick     = bba_pkg::lowest_set(nd_rdata & ~bba_pkg::range_mask('0, k_q));
  assign child_n  = nd_rdata[j_q] ? {node_q[bba_pkg::NodeW-2:0], 1'b1}
                                  : {node_q[bba_pkg::NodeW-2:0], 1'b0} + bba_pkg::NodeW'(2);
  assign parent_n = (node_q - bba_pkg::NodeW'(1)) >> 1;
  assign parent_m = mask_q | nd_rdata;
  assign f_ord    = (bk_rdata[bba_pkg::OrdW-1:0] > TopOrd) ? TopOrd
                                                            : bk_rdata[bba_pkg::OrdW-1:0];
  assign out_load = (state_q == S_RES) && (!out_valid_q || !out_stall_i);

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    k_d      = k_q;
    j_d      = j_q;
    o_d      = o_q;
    so_d     = so_q;
    ph_d     = ph_q;
    base_d   = base_q;
    addr_d   = addr_q;
    node_d   = node_q;
    mask_d   = mask_q;
    res_d    = res_q;
    nd_we    = 1'b0;
    nd_waddr = ix_n;
    nd_wdata = '0;
    nd_raddr = '0;
    bk_we    = 1'b0;
    bk_waddr = addr_q;
    bk_wdata = '0;
    bk_raddr = in_req_i.block_address;
    ix_a     = base_q;
    ix_o     = o_q;
    unique case (state_q)
      S_CLR: begin
        // Only the whole-heap block is free; no block is allocated.
        nd_we    = 1'b1;
        nd_waddr = clr_q;
        nd_wdata = (clr_q == '0) ? RootMask : '0;
        bk_we    = 1'b1;
        bk_waddr = clr_q[bba_pkg::AddrW-1:0];
        clr_d    = clr_q + bba_pkg::NodeW'(1);
        if (&clr_q) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          addr_d = in_req_i.block_address;
          k_d    = bba_pkg::size_order(in_req_i.req_size);
          if (in_req_i.req_type == bba_pkg::REQ_FREE) begin
            state_d = S_FCHK;
          end else if (in_req_i.req_size == '0 ||
                       in_req_i.req_size > bba_pkg::SizeW'(bba_pkg::HeapSize)) begin
            res_d   = '{status: bba_pkg::ST_BADSIZE, address: '0, order: '0};
            state_d = S_RES;
          end else begin
            state_d = S_AROOT;
          end
        end
      end
      S_AROOT: begin
        if (!pick[bba_pkg::OrdW]) begin
          res_d   = '{status: bba_pkg::ST_NOSPACE, address: '0, order: k_q};
          state_d = S_RES;
        end else begin
          j_d    = pick[bba_pkg::OrdW-1:0];
          base_d = '0;
          node_d = '0;
          o_d    = TopOrd;
          so_d   = k_q;
          ph_d   = 1'b0;
          if (pick[bba_pkg::OrdW-1:0] == TopOrd) begin
            state_d = S_ASPLIT;
          end else begin
            nd_raddr = bba_pkg::NodeW'(1);
            state_d  = S_ADESC;
          end
        end
      end
      S_ADESC: begin
        // Go left if the left child has a free block of order j.
        node_d = child_n;
        if (!nd_rdata[j_q]) base_d = base_q | (bba_pkg::AddrW'(1) << lvl_dn);
        o_d = lvl_dn;
        if (lvl_dn == j_q) begin
          state_d = S_ASPLIT;
        end else begin
          nd_raddr = {child_n[bba_pkg::NodeW-2:0], 1'b1};
        end
      end
      S_ASPLIT: begin
        ix_o  = so_q;
        nd_we = 1'b1;
        if (so_q == j_q) begin
          nd_wdata = bba_pkg::range_mask(k_q, j_q);
          node_d   = ix_n;
          mask_d   = bba_pkg::range_mask(k_q, j_q);
          o_d      = j_q;
          bk_we    = 1'b1;
          bk_waddr = base_q;
          bk_wdata = {1'b1, k_q};
          res_d    = '{status: bba_pkg::ST_OK, address: base_q, order: k_q};
          state_d  = (j_q == TopOrd) ? S_RES : S_UPRD;
        end else if (!ph_q) begin
          nd_wdata = bba_pkg::range_mask(k_q, so_q);
          ph_d     = 1'b1;
        end else begin
          // Upper half becomes a free block at its own order.
          ix_a     = base_q | (bba_pkg::AddrW'(1) << so_q);
          nd_wdata = bba_pkg::MaskW'(1) << so_q;
          ph_d     = 1'b0;
          so_d     = so_q + bba_pkg::OrdW'(1);
        end
      end
      S_FCHK: begin
        bk_raddr = addr_q;
        if (!bk_rdata[bba_pkg::OrdW]) begin
          res_d   = '{status: bba_pkg::ST_NOTALLOC, address: addr_q, order: '0};
          state_d = S_RES;
        end else begin
          bk_we    = 1'b1;
          bk_wdata = {1'b0, f_ord};
          k_d      = f_ord;
          o_d      = f_ord;
          base_d   = addr_q;
          ix_a     = addr_q;
          ix_o     = f_ord;
          if (f_ord == TopOrd) begin
            nd_we   = 1'b1;
            nd_wdata = RootMask;
            res_d   = '{status: bba_pkg::ST_OK, address: addr_q, order: f_ord};
            state_d = S_RES;
          end else begin
            nd_raddr = bba_pkg::sibling(ix_n);
            state_d  = S_FMRG;
          end
        end
      end
      S_FMRG: begin
        nd_we = 1'b1;
        if (nd_rdata[o_q]) begin
          // Buddy is free: absorb it and move up one order.
          nd_waddr = bba_pkg::sibling(ix_n);
          nd_wdata = '0;
          base_d   = base_q & ~(bba_pkg::AddrW'(1) << o_q);
          o_d      = lvl_up;
          state_d  = S_FZRO;
        end else begin
          nd_wdata = bba_pkg::MaskW'(1) << o_q;
          node_d   = ix_n;
          mask_d   = bba_pkg::MaskW'(1) << o_q;
          res_d    = '{status: bba_pkg::ST_OK, address: addr_q, order: k_q};
          state_d  = S_UPRD;
        end
      end
      S_FZRO: begin
        nd_we = 1'b1;
        if (o_q == TopOrd) begin
          nd_wdata = RootMask;
          res_d    = '{status: bba_pkg::ST_OK, address: addr_q, order: k_q};
          state_d  = S_RES;
        end else begin
          // Merged node is interior for now; cleared until its buddy is checked.
          nd_wdata = '0;
          nd_raddr = bba_pkg::sibling(ix_n);
          state_d  = S_FMRG;
        end
      end
      S_UPRD: begin
        nd_raddr = bba_pkg::sibling(node_q);
        state_d  = S_UP;
      end
      S_UP: begin
        nd_we    = 1'b1;
        nd_waddr = parent_n;
        nd_wdata = parent_m;
        node_d   = parent_n;
        mask_d   = parent_m;
        o_d      = lvl_up;
        if (lvl_up == TopOrd) begin
          state_d = S_RES;
        end else begin
          nd_raddr = bba_pkg::sibling(parent_n);
        end
      end
      S_RES: begin
        if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    j_q    <= j_d;
    o_q    <= o_d;
    so_q   <= so_d;
    ph_q   <= ph_d;
    base_q <= base_d;
    addr_q <= addr_d;
    node_q <= node_d;
    mask_q <= mask_d;
    res_q  <= res_d;
    if (out_load) out_q <= res_q;
  end

  bba_ram #(
    .Width(bba_pkg::MaskW),
    .Depth(bba_pkg::NodeDepth)
  ) u_node_ram (
    .clk_i  (clk_i),
    .we_i   (nd_we),
    .waddr_i(nd_waddr),
    .wdata_i(nd_wdata),
    .raddr_i(nd_raddr),
    .rdata_o(nd_rdata)
  );

  bba_ram #(
    .Width(bba_pkg::BlkW),
    .Depth(bba_pkg::HeapSize)
  ) u_blk_ram (
    .clk_i  (clk_i),
    .we_i   (bk_we),
    .waddr_i(bk_waddr),
    .wdata_i(bk_wdata),
    .raddr_i(bk_raddr),
    .rdata_o(bk_rdata)
  );

  // A response never reports an order beyond the heap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.order <= TopOrd)
    else $error("response order out of range");

  // A rejected size carries neither address nor order.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == bba_pkg::ST_BADSIZE |->
      out_rsp_o.address == '0 && out_rsp_o.order == '0)
    else $error("bad-size response carries payload");

  // A new response only appears after the sequencer has finished a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_RES)
    else $error("response without finished request");

endmodule
